// ===== hdl/bwpp_pkg.sv =====
// ----------------------------------------------------------------------------
// bwpp_pkg
// Shared types and constants for the byte window pattern patcher.
// ----------------------------------------------------------------------------
package bwpp_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIN_DEPTH  = 4;
  localparam int FILL_W     = $clog2(WIN_DEPTH);
  localparam int CD_W       = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_Y_FIX_EN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_FIX_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_VALUE_FIRST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_VALUE_SECOND = 2'd3;

  localparam logic [15:0] Y_FIRST_RST  = 16'd3;
  localparam logic [15:0] Y_SECOND_RST = 16'd0;

  // pattern bytes
  localparam logic [7:0] PAT_LEAD  = 8'h0A;
  localparam logic [7:0] PAT_ZERO  = 8'h00;
  localparam logic [7:0] PAT_A     = 8'h24;
  localparam logic [7:0] PAT_C     = 8'h04;
  localparam logic [7:0] PAT_TAIL  = 8'h86;
  localparam logic [7:0] FIX_LO    = 8'h90;
  localparam logic [7:0] FIX_HI    = 8'h93;
  localparam logic [7:0] FIX_TAIL  = 8'h24;
  localparam logic [7:0] PATCH_SUB = 8'd2;

  localparam logic [CD_W-1:0] CD_RELOAD = 4'd10;
  localparam logic [CD_W-1:0] CD_FIRST  = 4'd5;
  localparam logic [CD_W-1:0] CD_SECOND = 4'd4;

  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_TYPE_A = 2'd1,
    KIND_TYPE_C = 2'd2,
    KIND_FIX    = 2'd3
  } patch_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    patch_kind_t patch_kind;
    logic        last_of_run;
  } out_item_t;

  // one request's worth of output bytes, byte 0 goes out first
  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] bytes;
    logic [FILL_W-1:0]         cnt_m1;
    patch_kind_t               kind;
  } run_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [CD_W-1:0]   countdown;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

// ===== hdl/bwpp_front.sv =====
// ----------------------------------------------------------------------------
// bwpp_front - window gather, pattern classification and patching;
// one request per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module bwpp_front import bwpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  queue_stat_t           q_stat,
  output logic                  push,
  output run_t                  push_run,
  output front_stat_t           stat
);

  logic                       y_fix_en_r;
  logic                       screen_fix_en_r;
  logic [15:0]                y_first_r;
  logic [15:0]                y_second_r;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [CD_W-1:0]            cd_r, cd_nxt;
  logic [WIN_DEPTH-1:0][7:0]  win_r, win_nxt;

  logic [WIN_DEPTH-1:0][7:0]  w;
  logic                       accept;
  logic                       full;
  logic                       hdr, is_a, is_c, fixwin;
  logic [CD_W-1:0]            cd_dec, cd_m;
  logic [15:0]                yv;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign full     = (fill_r == FILL_W'(WIN_DEPTH - 1));

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w[i] = (fill_r == FILL_W'(i)) ? in_data.in_byte : win_r[i];
    end
  end

  assign cd_dec = (cd_r != '0) ? cd_r - CD_W'(1) : cd_r;
  assign hdr    = (w[0] == PAT_LEAD) && (w[1] == PAT_ZERO) && (w[3] == PAT_TAIL);
  assign is_a   = hdr && (w[2] == PAT_A);
  assign is_c   = hdr && (w[2] == PAT_C);
  assign cd_m   = ((is_a || is_c) && (y_fix_en_r || screen_fix_en_r)) ? CD_RELOAD : cd_dec;
  assign fixwin = ((cd_m == CD_FIRST) || (cd_m == CD_SECOND)) &&
                  (w[2] >= FIX_LO) && (w[2] <= FIX_HI) && (w[3] == FIX_TAIL);
  assign yv     = (cd_m == CD_FIRST) ? y_first_r : y_second_r;

  always_comb begin
    push_run.bytes  = w;
    push_run.cnt_m1 = FILL_W'(WIN_DEPTH - 1);
    push_run.kind   = KIND_PLAIN;
    push            = accept && (full || in_data.end_of_stream);
    priority if (!full) begin
      // only reached on end of stream: flush what is held
      push_run.cnt_m1 = fill_r;
    end else if (fixwin) begin
      push_run.kind = KIND_FIX;
      if (y_fix_en_r) begin
        push_run.bytes[0] = yv[7:0];
        push_run.bytes[1] = yv[15:8];
      end
      if (screen_fix_en_r && (w[2] > FIX_LO)) begin
        push_run.bytes[2] = w[2] - 8'd1;
      end
    end else if (is_a || is_c) begin
      push_run.kind     = is_a ? KIND_TYPE_A : KIND_TYPE_C;
      push_run.bytes[0] = w[0] - PATCH_SUB;
      push_run.bytes[3] = w[3] - PATCH_SUB;
    end else begin
      // plain copy of byte 0; end of stream sends the rest along with it
      push_run.cnt_m1 = in_data.end_of_stream ? FILL_W'(WIN_DEPTH - 1) : '0;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    cd_nxt   = cd_r;
    win_nxt  = w;
    if (accept) begin
      priority if (in_data.end_of_stream) begin
        fill_nxt = '0;
        cd_nxt   = '0;
      end else if (full) begin
        cd_nxt = cd_m;
        if (fixwin || is_a || is_c) begin
          fill_nxt = '0;
        end else begin
          fill_nxt = FILL_W'(WIN_DEPTH - 1);
          for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_nxt[i] = w[i+1];
          end
        end
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r          <= '0;
      cd_r            <= '0;
      y_fix_en_r      <= 1'b0;
      screen_fix_en_r <= 1'b0;
      y_first_r       <= Y_FIRST_RST;
      y_second_r      <= Y_SECOND_RST;
    end else begin
      fill_r <= fill_nxt;
      cd_r   <= cd_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_Y_FIX_EN:       y_fix_en_r      <= cfg_data[0];
          CFG_SCREEN_FIX_EN:  screen_fix_en_r <= cfg_data[0];
          CFG_Y_VALUE_FIRST:  y_first_r       <= cfg_data;
          CFG_Y_VALUE_SECOND: y_second_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  assign stat.fill      = fill_r;
  assign stat.countdown = cd_r;

endmodule

// ===== hdl/bwpp_queue.sv =====
// ----------------------------------------------------------------------------
// bwpp_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module bwpp_queue import bwpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  run_t        push_run,
  input  logic        pop,
  output run_t        head,
  output queue_stat_t stat
);

  run_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.valid = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// ===== hdl/bwpp_back.sv =====
// ----------------------------------------------------------------------------
// bwpp_back
// Holds one request; sends its bytes one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module bwpp_back import bwpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_stat_t q_stat,
  input  run_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  run_t              run_r;
  logic              valid_r;
  logic [FILL_W-1:0] idx_r;
  logic              last;
  logic              take;

  assign last      = (idx_r == run_r.cnt_m1);
  assign take      = valid_r && out_ready;
  assign pop       = q_stat.valid && (!valid_r || (take && last));
  assign out_valid = valid_r;

  assign out_data.out_byte    = run_r.bytes[idx_r];
  assign out_data.patch_kind  = run_r.kind;
  assign out_data.last_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      priority if (pop) begin
        valid_r <= 1'b1;
        idx_r   <= '0;
      end else if (take && last) begin
        valid_r <= 1'b0;
        idx_r   <= '0;
      end else if (take) begin
        idx_r <= idx_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      run_r <= head;
    end
  end

endmodule

// ===== hdl/byte_window_pattern_patcher_core.sv =====
// A request is registered in the queue entry and then in the back-end run register.
// Throughput: one input byte per cycle while each causes at most one result; the back
// end sends one byte per cycle while out_ready is high, so four-byte runs hold the input
// once the two-entry queue is full.
// Reset: synchronous, active low; clears window fill, countdown, queue and back end,
// and loads the configuration reset values. Window bytes are not reset.
// ----------------------------------------------------------------------------
// byte_window_pattern_patcher_core
// Four-byte window patcher: front classifies, queue decouples, back serialises.
// ----------------------------------------------------------------------------
module byte_window_pattern_patcher_core import bwpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  queue_stat_t q_stat;
  front_stat_t f_stat;
  logic        push, pop;
  run_t        push_run, head;

  bwpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_run  (push_run),
    .stat      (f_stat)
  );

  bwpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  bwpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.end_of_stream |=>
      (f_stat.fill == '0) && (f_stat.countdown == '0))
    else $error("end of stream did not clear window state");

  a_cd_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_stat.countdown <= CD_RELOAD)
    else $error("fix countdown out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("request pushed into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("request popped from empty queue");

endmodule

// ===== dv/bwpp_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bwpp_tb_pkg
// Scoreboard for the byte window pattern patcher: keeps its own copy of the
// window, countdown and registers, predicts the bytes each request causes and
// checks the result channel against them in order.
// ----------------------------------------------------------------------------
package bwpp_tb_pkg;
  import bwpp_pkg::*;

  class patch_scoreboard;
    bit [7:0]      win [WIN_DEPTH];
    int unsigned   fill;
    bit [CD_W-1:0] countdown;
    bit            y_fix_en;
    bit            screen_fix_en;
    bit [15:0]     y_first;
    bit [15:0]     y_second;
    out_item_t     expected_bytes [$];
    int unsigned   errors;

    function new();
      fill          = 0;
      countdown     = '0;
      y_fix_en      = 1'b0;
      screen_fix_en = 1'b0;
      y_first       = Y_FIRST_RST;
      y_second      = Y_SECOND_RST;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_Y_FIX_EN:       y_fix_en      = data[0];
        CFG_SCREEN_FIX_EN:  screen_fix_en = data[0];
        CFG_Y_VALUE_FIRST:  y_first       = data;
        CFG_Y_VALUE_SECOND: y_second      = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(bit [7:0] b, patch_kind_t kind);
      out_item_t r;
      r.out_byte    = b;
      r.patch_kind  = kind;
      r.last_of_run = 1'b0;
      expected_bytes.push_back(r);
    endfunction

    function void push_window(patch_kind_t kind);
      for (int i = 0; i < WIN_DEPTH; i++) push_byte(win[i], kind);
      fill = 0;
    endfunction

    // called once per accepted request
    function void note_request(in_item_t req);
      int unsigned start_cnt;
      patch_kind_t kind;
      bit [15:0]   yv;
      out_item_t   tail;
      start_cnt = expected_bytes.size();
      win[fill] = req.in_byte;
      fill++;
      if (fill == WIN_DEPTH) begin
        if (countdown != 0) countdown = countdown - 1'b1;
        kind = KIND_PLAIN;
        if (win[0] == PAT_LEAD && win[1] == PAT_ZERO && win[3] == PAT_TAIL) begin
          if (win[2] == PAT_A) kind = KIND_TYPE_A;
          else if (win[2] == PAT_C) kind = KIND_TYPE_C;
          if (kind != KIND_PLAIN && (y_fix_en || screen_fix_en)) countdown = CD_RELOAD;
        end
        // fix window takes priority over the mode patterns
        if ((countdown == CD_FIRST || countdown == CD_SECOND) &&
            win[2] >= FIX_LO && win[2] <= FIX_HI && win[3] == FIX_TAIL) begin
          if (y_fix_en) begin
            yv     = (countdown == CD_FIRST) ? y_first : y_second;
            win[0] = yv[7:0];
            win[1] = yv[15:8];
          end
          if (screen_fix_en && win[2] > FIX_LO) win[2] = win[2] - 8'd1;
          push_window(KIND_FIX);
        end else if (kind != KIND_PLAIN) begin
          win[0] = win[0] - PATCH_SUB;
          win[3] = win[3] - PATCH_SUB;
          push_window(kind);
        end else begin
          push_byte(win[0], KIND_PLAIN);
          for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i+1];
          fill = WIN_DEPTH - 1;
        end
      end
      if (req.end_of_stream) begin
        for (int i = 0; i < fill; i++) push_byte(win[i], KIND_PLAIN);
        fill      = 0;
        countdown = '0;
      end
      if (expected_bytes.size() > start_cnt) begin
        tail             = expected_bytes.pop_back();
        tail.last_of_run = 1'b1;
        expected_bytes.push_back(tail);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result byte %h kind %0d last %b",
                 $time, got.out_byte, got.patch_kind, got.last_of_run);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.patch_kind !== want.patch_kind ||
          got.last_of_run !== want.last_of_run) begin
        $display("%0t: mismatch exp byte %h kind %0d last %b, got byte %h kind %0d last %b",
                 $time, want.out_byte, want.patch_kind, want.last_of_run,
                 got.out_byte, got.patch_kind, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== dv/tb_byte_window_pattern_patcher_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_window_pattern_patcher_core
// Drives byte streams through the patcher: a directed opener on the mode
// patterns, fix windows and flushes, then random streams built mostly from
// pattern and fix-window sequences under several register settings, with
// random stalls on both channels and one long result-side hold.
// ----------------------------------------------------------------------------
module tb_byte_window_pattern_patcher_core;
  import bwpp_pkg::*;
  import bwpp_tb_pkg::*;

  localparam int LONG_HOLD = 150;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  patch_scoreboard sb = new();
  int unsigned     items_sent    = 0;
  bit              idle_on       = 1'b1;
  int unsigned     hold_requests = 0;
  int unsigned     holds_done    = 0;

  byte_window_pattern_patcher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("** byte_window_pattern_patcher_core: FAILED **");
    $finish;
  end

  // valid is left high after acceptance so back-to-back requests need no toggle
  task automatic send_item(logic [7:0] b, logic eos);
    in_item_t req;
    req.in_byte       = b;
    req.end_of_stream = eos;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    items_sent++;
  endtask

  task automatic send_pattern(bit type_c);
    send_item(PAT_LEAD, 1'b0);
    send_item(PAT_ZERO, 1'b0);
    send_item(type_c ? PAT_C : PAT_A, 1'b0);
    send_item(PAT_TAIL, 1'b0);
  endtask

  // pattern, then windows timed to land on countdown five and four
  task automatic send_fix_run(bit type_c, logic [7:0] b2_first, logic [7:0] b2_second,
                              bit both);
    send_pattern(type_c);
    repeat (6) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_item(b2_first, 1'b0);
    send_item(FIX_TAIL, 1'b0);
    if (both) begin
      repeat (2) send_item(8'($urandom_range(0, 255)), 1'b0);
      send_item(b2_second, 1'b0);
      send_item(FIX_TAIL, 1'b0);
    end
  endtask

  task automatic send_segment();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      send_fix_run(1'($urandom_range(0, 1)), 8'($urandom_range(FIX_LO - 1, FIX_HI + 1)),
                   8'($urandom_range(FIX_LO - 1, FIX_HI + 1)), $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 7) begin
      send_pattern(1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 6))
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
  endtask

  // extra cycles cover requests still in flight that cause no result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] y_en, logic [15:0] scr_en, logic [15:0] y_first,
                            logic [15:0] y_second);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idx  [4];
    vals = '{y_en, scr_en, y_first, y_second};
    idx  = '{CFG_Y_FIX_EN, CFG_SCREEN_FIX_EN, CFG_Y_VALUE_FIRST, CFG_Y_VALUE_SECOND};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) send_segment();
    drain();
  endtask

  // result side: random stall bursts, plus the long hold when asked
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_requests != holds_done) begin
        holds_done++;
        stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: patterns patch without arming the countdown, then a flush
    send_pattern(1'b0);
    send_pattern(1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    drain();

    // both fixes on: fix windows at countdown five and four, edge values of byte 2
    set_config(16'h0001, 16'h0001, 16'hFFFF, 16'h0000);
    send_fix_run(1'b0, FIX_LO, FIX_HI, 1'b1);
    drain();

    set_config(16'h0001, 16'h0000, 16'hFFFF, 16'h0000);
    random_phase(16);

    // upper bits of the enables must be ignored; long hold fills the block
    set_config(16'hFFFE, 16'h0001 | 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    hold_requests++;
    random_phase(16);

    set_config(16'h0001, 16'h0001, 16'h0000, 16'hFFFF);
    random_phase(16);

    idle_on = 1'b0;
    set_config(16'h0001, 16'h0001, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    random_phase(16);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** byte_window_pattern_patcher_core: PASSED **");
    end else begin
      $display("** byte_window_pattern_patcher_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bwpp_pkg.sv
hdl/bwpp_front.sv
hdl/bwpp_queue.sv
hdl/bwpp_back.sv
hdl/byte_window_pattern_patcher_core.sv
dv/bwpp_tb_pkg.sv
dv/tb_byte_window_pattern_patcher_core.sv
